// ===== rtl/pbts_pkg.sv =====
// Shared types and constants for the priority bitmap task scheduler.
package pbts_pkg;

    localparam int NUM_TASKS  = 32;
    localparam int NUM_LEVELS = 32;
    localparam int ID_W       = 5;
    localparam int CNT_W      = 6;

    localparam logic [7:0]  LOCK_MAX  = 8'd255;
    localparam logic [15:0] SLICE_RST = 16'd10;

    typedef enum logic [2:0] {
        OP_READY   = 3'd0,
        OP_REMOVE  = 3'd1,
        OP_DSTART  = 3'd2,
        OP_DEND    = 3'd3,
        OP_TICK    = 3'd4,
        OP_LOCK    = 3'd5,
        OP_UNLOCK  = 3'd6,
        OP_SCHED   = 3'd7
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_QU_INIT,
        S_QU_HEAD,
        S_QU_WALK,
        S_PUSH,
        S_TK_STEP,
        S_TK_SLICE,
        S_DU_WALK,
        S_SCHED,
        S_DONE
    } t_state;

endpackage

// ===== rtl/priority_bitmap_task_scheduler.sv =====
// Priority bitmap task scheduler: linked ready queues and delay list under a sequencer.
//
// Usage: drive i_opcode, i_task_id, i_task_priority and i_delay_ticks with
// start high; the request is taken at the edge where start is high and busy
// is low. busy stays high while the sequencer works. The result comes out on
// the o_ ports for exactly one cycle marked by o_done; the receiver cannot
// stall it and must capture it then.
// Lock and start delay go straight to the result; schedule and unlock pass
// through the schedule step first. A new request is taken in the cycle after
// the result. Ready and remove walk one ready queue, one link per cycle. End
// delay walks the delay list the same way. A tick steps through the delay
// list; each woken task is pushed to the head of its ready queue, after a
// walk of that queue when it was already ready; an expired slice walks and
// pushes the running task again, to the tail of its level. These walks come
// from the single link-read port each list has.
// i_slice_max_we writes the slice reload value; write it only while idle.
// Reset (i_rst_n low at a clock edge) empties all queues and the delay list,
// clears the lock count and tick count, makes task 0 running and loads the
// slice reload value of 10.
module priority_bitmap_task_scheduler (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [2:0]                i_opcode,
    input  logic [pbts_pkg::ID_W-1:0] i_task_id,
    input  logic [pbts_pkg::ID_W-1:0] i_task_priority,
    input  logic [31:0]               i_delay_ticks,
    input  logic                      i_slice_max_we,
    input  logic [15:0]               i_slice_max_wdata,
    output logic                      o_done,
    output logic [pbts_pkg::ID_W-1:0] o_next_task,
    output logic                      o_switch_request,
    output logic                      o_none_ready,
    output logic [7:0]                o_lock_level,
    output logic [5:0]                o_woken_count,
    output logic [31:0]               o_ticks_elapsed
);
    import pbts_pkg::*;

    t_state r_state, n_state;

    // per-task and per-level stores
    logic [ID_W-1:0]  r_ptask [NUM_TASKS];
    logic [ID_W-1:0]  r_qnext [NUM_TASKS];
    logic [ID_W-1:0]  r_qhead [NUM_LEVELS];
    logic [ID_W-1:0]  r_qtail [NUM_LEVELS];
    logic [CNT_W-1:0] r_qcount[NUM_LEVELS];
    logic [ID_W-1:0]  r_dnext [NUM_TASKS];
    logic [31:0]      r_rem   [NUM_TASKS];
    logic [NUM_TASKS-1:0] r_rdy;
    logic [NUM_TASKS-1:0] r_dly;

    logic [ID_W-1:0]  r_dl_head, r_dl_tail;
    logic [CNT_W-1:0] r_dl_len;

    logic [ID_W-1:0]  r_run;
    logic [15:0]      r_slice;
    logic [15:0]      r_slice_max;
    logic [7:0]       r_lock;
    logic [31:0]      r_ticks;
    logic             r_sw;
    logic [5:0]       r_woken;

    // command latch
    logic [ID_W-1:0]  r_tid;

    // queue / delay list walker
    logic [ID_W-1:0]  r_ut;
    logic [ID_W-1:0]  r_qp;
    logic [ID_W-1:0]  r_cur, r_prev;
    logic             r_pv;
    logic [CNT_W-1:0] r_n;
    logic [ID_W-1:0]  r_push_prio;
    logic             r_push_tail, r_push_pend, r_walk;

    // tick walker
    logic [ID_W-1:0]  r_tcur, r_tprev;
    logic             r_tpv;
    logic [CNT_W-1:0] r_tn, r_tlen;

    // level search over non-empty queues
    logic [ID_W-1:0]  w_lvl;
    logic             w_any;
    always_comb begin
        w_lvl = '0;
        w_any = 1'b0;
        for (int p = NUM_LEVELS - 1; p >= 0; p--) begin
            if (r_qcount[p] != '0) begin
                w_lvl = ID_W'(p);
                w_any = 1'b1;
            end
        end
    end

    // shared read ports
    logic [ID_W-1:0]  w_pa, w_ta, w_da;
    logic [ID_W-1:0]  w_head, w_tail, w_pt, w_qnx, w_dnx;
    logic [CNT_W-1:0] w_cnt;
    logic             w_flag;
    logic [31:0]      w_tk_rem;
    logic [15:0]      w_reload;

    assign w_pa = (r_state == S_PUSH) ? r_push_prio :
                  (r_state == S_SCHED) ? w_lvl : r_qp;
    assign w_ta = (r_state == S_TK_STEP) ? r_tcur :
                  (r_state == S_TK_SLICE) ? r_run : r_ut;
    assign w_da = (r_state == S_DU_WALK) ? r_cur : r_tcur;

    assign w_head   = r_qhead[w_pa];
    assign w_tail   = r_qtail[w_pa];
    assign w_cnt    = r_qcount[w_pa];
    assign w_pt     = r_ptask[w_ta];
    assign w_flag   = r_rdy[w_ta];
    assign w_qnx    = r_qnext[r_cur];
    assign w_dnx    = r_dnext[w_da];
    assign w_tk_rem = r_rem[r_tcur] - 32'd1;
    assign w_reload = (r_slice_max == '0) ? 16'd1 : r_slice_max;

    logic w_qu_end, w_qu_hit, w_du_end, w_du_hit, w_tk_end, w_tk_exp;
    logic w_slice_exp, w_sched_sw;
    assign w_qu_end    = r_n >= w_cnt;
    assign w_qu_hit    = r_cur == r_ut;
    assign w_du_end    = r_n >= r_dl_len;
    assign w_du_hit    = r_cur == r_tid;
    assign w_tk_end    = r_tn >= r_tlen;
    assign w_tk_exp    = w_tk_rem == '0;
    assign w_slice_exp = r_slice <= 16'd1;
    assign w_sched_sw  = (r_lock == '0) && w_any && (w_head != r_run);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    unique case (t_op'(i_opcode)) inside
                        OP_READY, OP_REMOVE: n_state = S_QU_INIT;
                        OP_DSTART, OP_LOCK:  n_state = S_DONE;
                        OP_DEND:   n_state = r_dly[i_task_id] ? S_DU_WALK : S_DONE;
                        OP_TICK:   n_state = S_TK_STEP;
                        OP_UNLOCK, OP_SCHED: n_state = S_SCHED;
                        default:   n_state = S_SCHED;
                    endcase
                end
            end
            S_QU_INIT: begin
                if (w_flag)           n_state = S_QU_HEAD;
                else if (r_push_pend) n_state = S_PUSH;
                else                  n_state = S_SCHED;
            end
            S_QU_HEAD: n_state = S_QU_WALK;
            S_QU_WALK: begin
                if (w_qu_end || w_qu_hit) n_state = r_push_pend ? S_PUSH : S_SCHED;
            end
            S_PUSH:    n_state = r_walk ? S_TK_STEP : S_SCHED;
            S_TK_STEP: begin
                if (w_tk_end)      n_state = S_TK_SLICE;
                else if (w_tk_exp) n_state = S_QU_INIT;
            end
            S_TK_SLICE: n_state = (w_slice_exp && w_flag) ? S_QU_INIT : S_SCHED;
            S_DU_WALK: begin
                if (w_du_end || w_du_hit) n_state = S_DONE;
            end
            S_SCHED:   n_state = S_DONE;
            S_DONE:    n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_LEVELS; i++) r_qcount[i] <= '0;
            r_rdy       <= '0;
            r_dly       <= '0;
            r_dl_len    <= '0;
            r_run       <= '0;
            r_slice     <= SLICE_RST;
            r_slice_max <= SLICE_RST;
            r_lock      <= '0;
            r_ticks     <= '0;
            r_sw        <= 1'b0;
            r_woken     <= '0;
            r_walk      <= 1'b0;
            r_push_pend <= 1'b0;
        end else begin
            if (i_slice_max_we) r_slice_max <= i_slice_max_wdata;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_tid   <= i_task_id;
                        r_sw    <= 1'b0;
                        r_woken <= '0;
                        r_walk  <= 1'b0;
                        r_ut    <= i_task_id;
                        r_push_prio <= i_task_priority;
                        r_push_tail <= 1'b0;
                        r_push_pend <= (t_op'(i_opcode) == OP_READY);
                        r_cur   <= r_dl_head;
                        r_n     <= '0;
                        r_pv    <= 1'b0;
                        r_tcur  <= r_dl_head;
                        r_tn    <= '0;
                        r_tlen  <= r_dl_len;
                        r_tpv   <= 1'b0;
                        case (t_op'(i_opcode))
                            OP_DSTART: begin
                                r_rem[i_task_id] <= (i_delay_ticks == '0) ? 32'd1
                                                                            : i_delay_ticks;
                                if (!r_dly[i_task_id]) begin
                                    if (r_dl_len == '0) r_dl_head <= i_task_id;
                                    else r_dnext[r_dl_tail] <= i_task_id;
                                    r_dl_tail <= i_task_id;
                                    r_dl_len  <= r_dl_len + 1'b1;
                                    r_dly[i_task_id] <= 1'b1;
                                end
                            end
                            OP_LOCK: begin
                                if (r_lock != LOCK_MAX) r_lock <= r_lock + 1'b1;
                            end
                            OP_UNLOCK: begin
                                if (r_lock != '0) r_lock <= r_lock - 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
                S_QU_INIT: begin
                    if (w_flag) r_qp <= w_pt;
                end
                S_QU_HEAD: begin
                    r_cur <= w_head;
                    r_n   <= '0;
                    r_pv  <= 1'b0;
                end
                S_QU_WALK: begin
                    if (w_qu_end) begin
                        r_rdy[r_ut] <= 1'b0;
                    end else if (w_qu_hit) begin
                        if (!r_pv) r_qhead[r_qp] <= w_qnx;
                        else r_qnext[r_prev] <= w_qnx;
                        if (w_tail == r_ut && r_pv) r_qtail[r_qp] <= r_prev;
                        r_qcount[r_qp] <= w_cnt - 1'b1;
                        r_rdy[r_ut]    <= 1'b0;
                    end else begin
                        r_prev <= r_cur;
                        r_pv   <= 1'b1;
                        r_cur  <= w_qnx;
                        r_n    <= r_n + 1'b1;
                    end
                end
                S_PUSH: begin
                    if (w_cnt == '0) begin
                        r_qhead[r_push_prio] <= r_ut;
                        r_qtail[r_push_prio] <= r_ut;
                    end else if (r_push_tail) begin
                        r_qnext[w_tail]      <= r_ut;
                        r_qtail[r_push_prio] <= r_ut;
                    end else begin
                        r_qnext[r_ut]        <= w_head;
                        r_qhead[r_push_prio] <= r_ut;
                    end
                    r_qcount[r_push_prio] <= w_cnt + 1'b1;
                    r_rdy[r_ut]   <= 1'b1;
                    r_ptask[r_ut] <= r_push_prio;
                end
                S_TK_STEP: begin
                    if (!w_tk_end) begin
                        r_rem[r_tcur] <= w_tk_rem;
                        if (w_tk_exp) begin
                            // drop from delay list, then ready at queue head
                            if (!r_tpv) r_dl_head <= w_dnx;
                            else r_dnext[r_tprev] <= w_dnx;
                            if (r_dl_tail == r_tcur && r_tpv) r_dl_tail <= r_tprev;
                            r_dl_len      <= r_dl_len - 1'b1;
                            r_dly[r_tcur] <= 1'b0;
                            r_woken       <= r_woken + 1'b1;
                            r_ut          <= r_tcur;
                            r_push_prio   <= w_pt;
                            r_push_tail   <= 1'b0;
                            r_push_pend   <= 1'b1;
                            r_walk        <= 1'b1;
                        end else begin
                            r_tprev <= r_tcur;
                            r_tpv   <= 1'b1;
                        end
                        r_tcur <= w_dnx;
                        r_tn   <= r_tn + 1'b1;
                    end
                end
                S_TK_SLICE: begin
                    r_ticks <= r_ticks + 1'b1;
                    r_walk  <= 1'b0;
                    if (w_slice_exp) begin
                        r_slice <= w_reload;
                        // rotate the running task to the tail of its level
                        r_ut        <= r_run;
                        r_push_prio <= w_pt;
                        r_push_tail <= 1'b1;
                        r_push_pend <= 1'b1;
                    end else begin
                        r_slice <= r_slice - 1'b1;
                    end
                end
                S_DU_WALK: begin
                    if (w_du_end) begin
                        r_dly[r_tid] <= 1'b0;
                    end else if (w_du_hit) begin
                        if (!r_pv) r_dl_head <= w_dnx;
                        else r_dnext[r_prev] <= w_dnx;
                        if (r_dl_tail == r_tid && r_pv) r_dl_tail <= r_prev;
                        r_dl_len     <= r_dl_len - 1'b1;
                        r_dly[r_tid] <= 1'b0;
                    end else begin
                        r_prev <= r_cur;
                        r_pv   <= 1'b1;
                        r_cur  <= w_dnx;
                        r_n    <= r_n + 1'b1;
                    end
                end
                S_SCHED: begin
                    if (w_sched_sw) begin
                        r_run   <= w_head;
                        r_slice <= w_reload;
                        r_sw    <= 1'b1;
                    end
                end
                S_DONE: ;
                default: ;
            endcase
        end
    end

    assign busy             = r_state != S_IDLE;
    assign o_done           = r_state == S_DONE;
    assign o_next_task      = r_run;
    assign o_switch_request = r_sw;
    assign o_none_ready     = !w_any;
    assign o_lock_level     = r_lock;
    assign o_woken_count    = r_woken;
    assign o_ticks_elapsed  = r_ticks;

endmodule
